@@ hdl/sorted_table_binary_search_macros.svh @@
// Assertion macros shared by the sorted table search modules.
// Expects signals clk and rst in the module that uses them.
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

// Clocked property, switched off while reset is high
`define STB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication built on the clocked form
`define STB_IMPLIES(lbl, ante, cons, msg) \
  `STB_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

@@ hdl/stbs_pkg.sv @@
// Package for the sorted table search block: field widths, word types,
// request codes and controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps

package stbs_pkg;

  localparam int IDX_W          = 10;
  localparam int VAL_W          = 32;
  localparam int CFG_W          = 11;
  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KEY_WIDTH_DEF   = 32;

  // Request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Input word
  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] entry_index;
    logic [VAL_W-1:0] key_value;
  } req_t;

  // Result word
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] match_index;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load_we;   // write one table entry
    logic start;     // open a search, issue first probe
    logic step;      // compare probe, narrow range, issue next probe
    logic push;      // move search outcome into output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;  // table in use is empty
    logic step_done;   // match, or range now empty
  } sts_t;

endpackage

@@ hdl/stbs_ctrl.sv @@
// Controller for the sorted table search: accepts words, sequences the
// search steps and owns the result valid flag. Uses stbs_pkg and the macros.
`timescale 1ns / 1ps
`include "sorted_table_binary_search_macros.svh"

module stbs_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  input  logic          req_type,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  input  stbs_pkg::sts_t sts,
  output stbs_pkg::cmd_t cmd
);
  import stbs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_RESULT = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;
  logic   out_free;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req_type == REQ_SEARCH) begin
            cmd.start  = 1'b1;
            state_next = sts.count_zero ? ST_RESULT : ST_SEARCH;
          end else begin
            cmd.load_we = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.step_done) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.push   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `STB_IMPLIES(a_push_no_overwrite, cmd.push, !rsp_valid || !rsp_stall, "result word overwritten")
  `STB_ASSERT(a_search_enters_loop, (cmd.start && !sts.count_zero) |=> (state == ST_SEARCH), "search did not start stepping")
  `STB_ASSERT(a_push_sets_valid, cmd.push |=> rsp_valid, "pushed result not shown")

endmodule

@@ hdl/stbs_dp.sv @@
// Datapath for the sorted table search: key table memory, entry count,
// search range, compare and result register. Uses stbs_pkg and the macros.
`timescale 1ns / 1ps
`include "sorted_table_binary_search_macros.svh"

module stbs_dp #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = stbs_pkg::KEY_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [stbs_pkg::CFG_W-1:0] cfg_data,
  input  stbs_pkg::req_t             req,
  input  stbs_pkg::cmd_t             cmd,
  output stbs_pkg::sts_t             sts,
  output stbs_pkg::rsp_t             rsp
);
  import stbs_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];
  logic [KEY_WIDTH-1:0] probe;
  logic [KEY_WIDTH-1:0] search_key;
  logic [CFG_W-1:0]     entry_count;
  logic [CNT_W-1:0]     count_sat;
  logic [CNT_W-1:0]     range_low, range_high;
  logic [CNT_W-1:0]     low_next, high_next;
  logic [CNT_W-1:0]     span_next, mid_sum;
  logic [ADDR_W-1:0]    mid, mid_next, rd_addr;
  logic                 rd_en;
  logic                 wr_ok;
  logic                 key_eq, key_lt, empty_next;
  logic                 hit;
  logic [IDX_W-1:0]     hit_index;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_data;
    end
  end

  // Count clipped to the table depth
  always_comb begin
    if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
      count_sat = CNT_W'(TABLE_DEPTH);
    end else begin
      count_sat = CNT_W'(entry_count);
    end
  end

  // Probe compare and narrowed range
  assign key_eq = (search_key == probe);
  assign key_lt = (search_key < probe);
  always_comb begin
    if (key_lt) begin
      low_next  = range_low;
      high_next = CNT_W'(mid);
    end else begin
      low_next  = CNT_W'(mid) + CNT_W'(1);
      high_next = range_high;
    end
  end
  assign empty_next = (low_next >= high_next);
  assign span_next  = high_next - low_next;
  assign mid_sum    = low_next + (span_next >> 1);
  assign mid_next   = ADDR_W'(mid_sum);

  assign sts.count_zero = (entry_count == '0);
  assign sts.step_done  = key_eq || empty_next;

  // Probe address: first midpoint on start, narrowed midpoint on each step
  assign rd_addr = cmd.start ? ADDR_W'(count_sat >> 1) : mid_next;
  assign rd_en   = cmd.start || cmd.step;

  // Table memory, one write port and one registered read port
  assign wr_ok = (32'(req.entry_index) < 32'(TABLE_DEPTH));
  always_ff @(posedge clk) begin
    if (cmd.load_we && wr_ok) begin
      key_mem[ADDR_W'(req.entry_index)] <= KEY_WIDTH'(req.key_value);
    end
    if (rd_en) begin
      probe <= key_mem[rd_addr];
    end
  end

  // Search range and outcome
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= '0;
    end else if (cmd.start) begin
      range_low  <= '0;
      range_high <= count_sat;
    end else if (cmd.step) begin
      range_low  <= low_next;
      range_high <= high_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      search_key <= KEY_WIDTH'(req.key_value);
      hit        <= 1'b0;
      hit_index  <= '0;
    end else if (cmd.step) begin
      hit        <= key_eq;
      hit_index  <= key_eq ? IDX_W'(mid) : '0;
    end
    if (rd_en) begin
      mid <= rd_addr;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rsp.found       <= hit;
      rsp.match_index <= hit_index;
    end
  end

  `STB_IMPLIES(a_step_range_open, cmd.step, range_low < range_high, "step on empty range")
  `STB_ASSERT(a_range_shrinks, cmd.step |=> ((range_high - range_low) < $past(range_high - range_low)), "search range did not shrink")
  `STB_IMPLIES(a_probe_in_range, cmd.step, (CNT_W'(mid) >= range_low) && (CNT_W'(mid) < range_high), "probe outside range")

endmodule

@@ hdl/sorted_table_binary_search.sv @@
// Sorted table search, top level. A load word writes one entry and gives no result.
// A search word: the accept edge issues the first of up to floor(log2(count))+1 probes
// (one memory read and compare each); the outcome then moves into the output register
// once that register is free. An empty table skips the probes. The next word is taken
// the cycle after the result is registered, even if it waits.
// Reset (rst, synchronous) clears entry_count and control; the table is not cleared.
`timescale 1ns / 1ps

module sorted_table_binary_search #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_WIDTH   = stbs_pkg::KEY_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [stbs_pkg::CFG_W-1:0] cfg_data,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  stbs_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output stbs_pkg::rsp_t             rsp
);
  import stbs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_type  (req.req_type),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table, range and compare
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .cmd      (cmd),
    .sts      (sts),
    .rsp      (rsp)
  );

endmodule

@@ tb/tb_sorted_table_binary_search.sv @@
// Self-checking testbench for sorted_table_binary_search: loads and searches, results
// checked against a local halving-search predictor. Depends on stbs_pkg and the block itself.
`timescale 1ns / 1ps

module tb_sorted_table_binary_search;
  import stbs_pkg::*;

  localparam int SLOTS       = TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int WORD_TARGET = 1950;

  // Predictor and store of expected search results
  class table_scoreboard;
    logic [VAL_W-1:0] keys [SLOTS];
    int unsigned      entry_cnt;
    rsp_t             pending_hits [$];
    int               errors;
    int               checked;

    function new();
      entry_cnt = 0;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_count(int unsigned v);
      entry_cnt = v & 'h7FF;
    endfunction

    function int pending();
      return pending_hits.size();
    endfunction

    // halving search over [0, count), count saturated at table depth
    function rsp_t lookup_key(logic [VAL_W-1:0] key);
      int unsigned lo, hi, mid;
      rsp_t r;
      r  = '0;
      lo = 0;
      hi = (entry_cnt > SLOTS) ? SLOTS : entry_cnt;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (key == keys[mid]) begin
          r.found       = 1'b1;
          r.match_index = mid[IDX_W-1:0];
          break;
        end else if (key < keys[mid]) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
      return r;
    endfunction

    function void note_word(req_t w);
      if (w.req_type == REQ_LOAD) begin
        keys[w.entry_index] = w.key_value;
      end else begin
        pending_hits.push_back(lookup_key(w.key_value));
      end
    endfunction

    function void check_word(rsp_t got);
      rsp_t want;
      if (pending_hits.size() == 0) begin
        $error("unexpected result word: found=%0d match_index=%0d",
               got.found, got.match_index);
        errors++;
        return;
      end
      want = pending_hits.pop_front();
      checked++;
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        errors++;
      end
      if (got.match_index !== want.match_index) begin
        $error("match_index: expected %0d, got %0d", want.match_index, got.match_index);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  logic             req_valid;
  logic             req_stall;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_stall;
  rsp_t             rsp;

  table_scoreboard  sb;
  logic [VAL_W-1:0] shadow [SLOTS];
  bit               written [SLOTS];
  bit               idle_on;
  int               words_sent;
  int               searches_sent;
  int               cycles;
  int               hold_asks;
  int               hold_seen;
  int               hold_left;
  int               stall_left;

  sorted_table_binary_search dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: check accepted words, draw stalls, long hold on request
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      sb.check_word(rsp);
    end
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (!rst && rsp_valid && !rsp_stall) begin
      stall_left = idle_on ? $urandom_range(0, 3) : 0;
      rsp_stall <= (stall_left != 0);
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= (stall_left != 0);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Offer one word after a drawn gap, return at its accepting edge
  task automatic send_word(req_t w);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_stall);
    sb.note_word(w);
    words_sent++;
    if (w.req_type == REQ_SEARCH) searches_sent++;
  endtask

  task automatic load_entry(int idx, logic [VAL_W-1:0] val);
    req_t w;
    w.req_type    = REQ_LOAD;
    w.entry_index = idx[IDX_W-1:0];
    w.key_value   = val;
    shadow[idx]   = val;
    written[idx]  = 1'b1;
    send_word(w);
  endtask

  task automatic search_key(logic [VAL_W-1:0] key);
    req_t w;
    w.req_type    = REQ_SEARCH;
    w.entry_index = IDX_W'($urandom_range(0, SLOTS - 1));
    w.key_value   = key;
    send_word(w);
  endtask

  // Let the block go idle, then write the entry count
  task automatic write_count(int unsigned v);
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_data <= v[CFG_W-1:0];
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_count(v);
  endtask

  // Sorted random keys into entries [0, n), with some duplicates
  task automatic load_sorted_prefix(int n);
    logic [VAL_W-1:0] vals [$];
    for (int i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 5) == 0) vals.push_back(vals[i-1]);
      else vals.push_back($urandom);
    end
    vals.sort();
    for (int i = 0; i < n; i++) load_entry(i, vals[i]);
  endtask

  // Mostly keys in the table, some neighbors, some anything
  function automatic logic [VAL_W-1:0] pick_key(int n);
    int sel;
    logic [VAL_W-1:0] k;
    sel = $urandom_range(0, 9);
    if (n == 0 || sel >= 8) return $urandom;
    k = shadow[$urandom_range(0, n - 1)];
    if (sel >= 6) k = $urandom_range(0, 1) ? k + 1 : k - 1;
    return k;
  endfunction

  task automatic run_phase(int unsigned n, int words, bit reload, bit with_hold);
    int used;
    int idx;
    used    = (n > SLOTS) ? SLOTS : n;
    idle_on = ($urandom_range(0, 3) != 0);
    if (reload) load_sorted_prefix(used);
    for (int i = 0; i < used; i++) begin
      if (!written[i]) load_entry(i, $urandom);
    end
    write_count(n);
    if (with_hold) hold_asks <= hold_asks + 1;
    repeat (words) begin
      if ($urandom_range(0, 9) == 0) begin
        idx = $urandom_range(0, SLOTS - 1);
        load_entry(idx, $urandom);
      end else begin
        search_key(pick_key(used));
      end
    end
  endtask

  initial begin
    clk        = 1'b0;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    req_valid  = 1'b0;
    req        = '0;
    rsp_stall  = 1'b0;
    idle_on    = 1'b0;
    words_sent = 0;
    searches_sent = 0;
    cycles     = 0;
    hold_asks  = 0;
    hold_seen  = 0;
    hold_left  = 0;
    stall_left = 0;
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table after reset: every search misses
    search_key('0);
    search_key('1);

    // Small table with extreme keys and a duplicate pair
    load_entry(0, '0);
    load_entry(1, 32'd5);
    load_entry(2, 32'd5);
    load_entry(3, 32'd9);
    load_entry(4, '1);
    write_count(5);
    search_key('0);
    search_key(32'd5);
    search_key(32'd9);
    search_key('1);
    search_key(32'd3);
    search_key(32'd10);

    // Single entry in use
    write_count(1);
    search_key('0);
    search_key(32'd5);

    // Unsorted table: a present key can be missed, a real match still found
    load_entry(1, 32'd1);
    load_entry(3, 32'd2);
    write_count(5);
    search_key(32'd2);
    search_key('1);
    search_key(32'd1);

    // Full table, long receiver hold, then a count above the depth
    run_phase(SLOTS, 120, 1'b1, 1'b1);
    run_phase(11'h7FF, 40, 1'b0, 1'b0);

    // Many small tables, an occasional full-depth pass
    while (words_sent < WORD_TARGET) begin
      case ($urandom_range(0, 9))
        0:       run_phase(SLOTS, 30, 1'b0, 1'b0);
        1, 2:    run_phase($urandom_range(0, 4), 30, 1'b1, 1'b0);
        default: run_phase($urandom_range(5, 60), 30, $urandom_range(0, 3) != 0, 1'b0);
      endcase
    end

    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("sent %0d words (%0d searches), checked %0d results", words_sent,
             searches_sent, sb.checked);
    $display("table sizes 0 to full depth, saturated count, duplicate and unsorted keys");
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
